@@ rtl/core/lcdnw_pkg.sv @@
// Package: widths, codes and constant tables for the LCD decimal number writer.
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

    localparam int ROWS       = 4;
    localparam int COLS       = 8;
    localparam int MAX_DIGITS = 5;

    localparam int VALUE_W = 16;
    localparam int COUNT_W = 7;
    localparam int POS_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int DIGITS  = 5;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int NDIG_W  = 3;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_LEAD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_BASE = 2'd1;

    localparam logic [BYTE_W-1:0] WIDE_LEAD_RST = 8'hA3;
    localparam logic [BYTE_W-1:0] WIDE_BASE_RST = 8'hB0;

    localparam logic [BYTE_W-1:0] SYNC_CMD   = 8'hF8;
    localparam logic [BYTE_W-1:0] SYNC_DATA  = 8'hFA;
    localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;
    localparam logic [BYTE_W-1:0] NIBBLE_HI  = 8'hF0;

    localparam logic [BYTE_W-1:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    localparam logic [1:0] FRM_SYNC = 2'd0;
    localparam logic [1:0] FRM_HIGH = 2'd1;
    localparam logic [1:0] FRM_LOW  = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
        logic [NDIG_W-1:0]  ndig;
        logic               wide;
        logic               has_addr;
        logic [BYTE_W-1:0]  cmd;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/core/lcdnw_if.sv @@
// Interfaces: input word, result word and configuration write channels.
`timescale 1ns / 1ps
`default_nettype none

interface lcdnw_in_if;
    import lcdnw_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] digit_count;
    logic               full_width;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   column;
    modport source (output valid, value, digit_count, full_width, row, column, input ready);
    modport sink   (input valid, value, digit_count, full_width, row, column, output ready);
endinterface

interface lcdnw_out_if;
    import lcdnw_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] serial_byte;
    logic              last;
    modport source (output valid, serial_byte, last, input ready);
    modport sink   (input valid, serial_byte, last, output ready);
endinterface

interface lcdnw_cfg_if;
    import lcdnw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lcd_decimal_number_writer.sv @@
// Top level: decimal number to serial LCD frame stream, pipelined BCD conversion and framer.
// Each LCD byte goes out as three frames (sync, high nibble, low nibble); a word with nothing
// to send is taken from the pipeline without frames. Conversion is a 5-stage pipeline,
// the framer sets the rate and stalls the pipeline while it is busy.
// Reset (synchronous, active low) empties the pipeline, framer and output register
// and restores the wide-digit registers to 0xA3 / 0xB0.
`timescale 1ns / 1ps
`default_nettype none

module lcd_decimal_number_writer
    import lcdnw_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    lcdnw_in_if.sink    i_in,
    lcdnw_cfg_if.sink   i_cfg,
    lcdnw_out_if.source o_out
);

    localparam int STAGES = 5;

    function automatic t_item dd4(t_item it);
        t_item r;
        r = it;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (r.bcd[d*4 +: 4] >= 4'd5) begin
                    r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
                end
            end
            {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

    // configuration
    logic [BYTE_W-1:0] r_wide_lead;
    logic [BYTE_W-1:0] r_wide_base;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_lead <= WIDE_LEAD_RST;
            r_wide_base <= WIDE_BASE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WIDE_LEAD: r_wide_lead <= i_cfg.data;
                CFG_WIDE_BASE: r_wide_base <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // conversion pipeline
    t_item r_st [STAGES];
    logic  r_v  [STAGES];
    t_item n_item;
    logic  pipe_en;
    logic  seq_load;

    assign pipe_en    = !r_v[STAGES-1] || seq_load;
    assign i_in.ready = pipe_en;

    always_comb begin
        n_item      = '0;
        n_item.bin  = i_in.value;
        n_item.ndig = (i_in.digit_count > COUNT_W'(MAX_DIGITS))
                      ? NDIG_W'(MAX_DIGITS) : i_in.digit_count[NDIG_W-1:0];
        n_item.wide = i_in.full_width;
        n_item.has_addr = (i_in.row < POS_W'(ROWS)) && (i_in.column < POS_W'(COLS));
        n_item.cmd  = ROW_BASE[i_in.row[1:0]] | {4'h0, i_in.column[3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STAGES; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_v[0] <= i_in.valid;
            for (int k = 1; k < STAGES; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_st[0] <= n_item;
            for (int k = 1; k < STAGES; k++) begin
                r_st[k] <= dd4(r_st[k-1]);
            end
        end
    end

    // framer
    logic              r_busy;
    logic              r_has_cmd;
    logic [NDIG_W-1:0] r_dig;
    logic              r_half;
    logic [1:0]        r_frm;
    logic              r_wide;
    logic [BYTE_W-1:0] r_cmd;
    logic [3:0]        r_digs [DIGITS];

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              out_free;
    logic              gen;
    logic              is_last;
    logic              has_work;
    logic [NDIG_W-1:0] ptr;
    logic [3:0]        cur_dig;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] n_frame;

    assign out_free = !r_out_valid || o_out.ready;
    assign gen      = r_busy && out_free;
    assign ptr      = r_dig - NDIG_W'(1);
    assign cur_dig  = r_digs[ptr];
    assign is_last  = (r_frm == FRM_LOW) &&
                      ((r_has_cmd && r_dig == '0) ||
                       (!r_has_cmd && r_dig == NDIG_W'(1) && (!r_wide || r_half)));
    assign seq_load = r_v[STAGES-1] && (!r_busy || (gen && is_last));
    assign has_work = r_st[STAGES-1].has_addr || (r_st[STAGES-1].ndig != '0);

    always_comb begin
        if (r_has_cmd) begin
            cur_byte = r_cmd;
        end else if (r_wide) begin
            cur_byte = r_half ? (r_wide_base + {4'h0, cur_dig}) : r_wide_lead;
        end else begin
            cur_byte = ASCII_ZERO + {4'h0, cur_dig};
        end
        case (r_frm)
            FRM_SYNC: n_frame = r_has_cmd ? SYNC_CMD : SYNC_DATA;
            FRM_HIGH: n_frame = cur_byte & NIBBLE_HI;
            FRM_LOW:  n_frame = {cur_byte[3:0], 4'h0};
            default:  n_frame = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_frm       <= FRM_SYNC;
        end else begin
            if (out_free) begin
                r_out_valid <= gen;
            end
            if (seq_load) begin
                r_busy <= has_work;
                r_frm  <= FRM_SYNC;
            end else if (gen) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_frm <= (r_frm == FRM_LOW) ? FRM_SYNC : r_frm + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen) begin
            r_out_byte <= n_frame;
            r_out_last <= is_last;
        end
        if (seq_load) begin
            r_has_cmd <= r_st[STAGES-1].has_addr;
            r_dig     <= r_st[STAGES-1].ndig;
            r_half    <= 1'b0;
            r_wide    <= r_st[STAGES-1].wide;
            r_cmd     <= r_st[STAGES-1].cmd;
            for (int d = 0; d < DIGITS; d++) begin
                r_digs[d] <= r_st[STAGES-1].bcd[d*4 +: 4];
            end
        end else if (gen && r_frm == FRM_LOW) begin
            if (r_has_cmd) begin
                r_has_cmd <= 1'b0;
            end else if (r_wide && !r_half) begin
                r_half <= 1'b1;
            end else begin
                r_half <= 1'b0;
                r_dig  <= r_dig - NDIG_W'(1);
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.serial_byte = r_out_byte;
    assign o_out.last        = r_out_last;

`ifndef NO_ASSERTIONS
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_has_cmd |-> r_dig != '0 && r_dig <= NDIG_W'(MAX_DIGITS))
        else $error("framer busy with no byte left");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_load && has_work |=> r_busy && r_frm == FRM_SYNC)
        else $error("framer did not start a loaded word at its sync frame");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[STAGES-1] && !seq_load |=> r_v[STAGES-1])
        else $error("pipeline dropped a stalled word");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen && is_last && !seq_load |=> !r_busy)
        else $error("framer kept running after last frame");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the LCD decimal number writer: random and directed words, frame-by-frame check.
module tb;
    import lcdnw_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_WORDS   = 58;
    localparam int N_DIRECTED    = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam logic [3:0]           UNTYPED   = 4'hF;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic               full_width;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
    } t_word;

    // typed bytes are left-aligned: first LCD byte in the top eight bits
    typedef struct packed {
        t_word               w;
        logic [3:0]          n_typed;
        logic                typed_cmd;
        logic [5*BYTE_W-1:0] typed;
    } t_case;

    typedef struct packed {
        logic [BYTE_W-1:0] serial_byte;
        logic              last;
    } t_frame;

    logic i_clk;
    logic i_rst_n;

    lcdnw_in_if  in_if ();
    lcdnw_cfg_if cfg_if ();
    lcdnw_out_if out_if ();

    lcd_decimal_number_writer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_frame            frames_due[$];
    logic [BYTE_W-1:0] lead_byte;
    logic [BYTE_W-1:0] digit_base;
    int                mismatches  = 0;
    int                holds_asked = 0;
    int                holds_done  = 0;
    int                hold_left   = 0;
    int                run_left    = 0;
    logic              run_ready   = 1'b0;
    int                idle_cycles = 0;
    t_case             directed_cases[N_DIRECTED];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string what, input int want, input int got);
        if (mismatches < 10)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic push_lcd_byte(input logic [BYTE_W-1:0] b, input logic is_cmd,
                                 input logic is_last);
        frames_due.push_back({is_cmd ? SYNC_CMD : SYNC_DATA, 1'b0});
        frames_due.push_back({b & NIBBLE_HI, 1'b0});
        frames_due.push_back({(b << 4) & NIBBLE_HI, is_last});
    endtask

    task automatic predict_frames(input t_word w);
        logic [BYTE_W:0] lcd_bytes[$];
        int n;
        int scale;
        int d;
        n = (w.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(w.digit_count);
        if (w.row < ROWS && w.column < COLS)
            lcd_bytes.push_back({1'b1, ROW_BASE[w.row[1:0]] | {4'h0, w.column[3:0]}});
        for (int i = n; i > 0; i--) begin
            scale = 1;
            repeat (i - 1) scale *= 10;
            d = (w.value / scale) % 10;
            if (w.full_width) begin
                lcd_bytes.push_back({1'b0, lead_byte});
                lcd_bytes.push_back({1'b0, digit_base + BYTE_W'(d)});
            end else begin
                lcd_bytes.push_back({1'b0, ASCII_ZERO + BYTE_W'(d)});
            end
        end
        foreach (lcd_bytes[k])
            push_lcd_byte(lcd_bytes[k][BYTE_W-1:0], lcd_bytes[k][BYTE_W],
                          k == lcd_bytes.size() - 1);
    endtask

    task automatic push_typed(input t_case c);
        for (int k = 0; k < c.n_typed; k++)
            push_lcd_byte(c.typed[5*BYTE_W-1-BYTE_W*k -: BYTE_W], c.typed_cmd && k == 0,
                          k == c.n_typed - 1);
    endtask

    function automatic t_case mk_case(input int value, input int count, input int wide,
                                      input int row, input int col, input logic [3:0] n_typed,
                                      input int typed_cmd, input logic [5*BYTE_W-1:0] typed);
        t_case c;
        c.w.value       = VALUE_W'(value);
        c.w.digit_count = COUNT_W'(count);
        c.w.full_width  = 1'(wide);
        c.w.row         = POS_W'(row);
        c.w.column      = POS_W'(col);
        c.n_typed       = n_typed;
        c.typed_cmd     = 1'(typed_cmd);
        c.typed         = typed;
        return c;
    endfunction

    function automatic t_word random_word();
        t_word w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: w.value = VALUE_W'($urandom_range(0, 65535));
            5, 6:          w.value = VALUE_W'($urandom_range(0, 999));
            7:             w.value = $urandom_range(0, 1) ? '1 : '0;
            default:       w.value = VALUE_W'($urandom_range(9990, 10009));
        endcase
        w.digit_count = ($urandom_range(0, 9) < 8) ? COUNT_W'($urandom_range(0, 7))
                                                   : COUNT_W'($urandom_range(8, 127));
        w.full_width  = 1'($urandom_range(0, 1));
        w.row         = ($urandom_range(0, 3) != 0) ? POS_W'($urandom_range(0, ROWS))
                                                    : POS_W'($urandom_range(0, 255));
        w.column      = ($urandom_range(0, 3) != 0) ? POS_W'($urandom_range(0, COLS))
                                                    : POS_W'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 0;
        if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(input t_word w, input int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.value       <= w.value;
        in_if.digit_count <= w.digit_count;
        in_if.full_width  <= w.full_width;
        in_if.row         <= w.row;
        in_if.column      <= w.column;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        if (idx == CFG_WIDE_LEAD)
            lead_byte = val;
        else if (idx == CFG_WIDE_BASE)
            digit_base = val;
    endtask

    // drain all expected frames, then let words with nothing to send clear the pipe
    task automatic settle();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (frames_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_frame want;
        if (out_if.valid && out_if.ready) begin
            if (frames_due.size() == 0) begin
                note_mismatch("unexpected word", -1, int'(out_if.serial_byte));
            end else begin
                want = frames_due.pop_front();
                if (out_if.serial_byte !== want.serial_byte)
                    note_mismatch("serial_byte", int'(want.serial_byte),
                                  int'(out_if.serial_byte));
                if (out_if.last !== want.last)
                    note_mismatch("last", int'(want.last), int'(out_if.last));
            end
        end
    end

    always @(posedge i_clk) begin : result_sink
        int r;
        if (holds_asked != holds_done) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            if (run_left == 0) begin
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    run_ready = 1'b1;
                    run_left  = $urandom_range(1, 8);
                end else if (r == 5) begin
                    run_ready = 1'b1;
                    run_left  = $urandom_range(30, 80);
                end else if (r < 9) begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(1, 3);
                end else begin
                    run_ready = 1'b0;
                    run_left  = $urandom_range(10, 40);
                end
            end
            run_left--;
            out_if.ready <= run_ready;
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_word w;
        in_if.valid       <= 1'b0;
        in_if.value       <= '0;
        in_if.digit_count <= '0;
        in_if.full_width  <= 1'b0;
        in_if.row         <= '0;
        in_if.column      <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        i_rst_n           <= 1'b0;
        lead_byte  = WIDE_LEAD_RST;
        digit_base = WIDE_BASE_RST;

        // value, count, wide, row, col, typed bytes, first is command, bytes
        directed_cases[0]  = mk_case(0, 0, 0, 4, 0, 4'd0, 0, 40'h0);
        directed_cases[1]  = mk_case(0, 0, 0, 0, 0, 4'd1, 1, 40'h80_00000000);
        directed_cases[2]  = mk_case(0, 0, 0, 1, 7, 4'd1, 1, 40'h97_00000000);
        directed_cases[3]  = mk_case(0, 0, 0, 2, 3, 4'd1, 1, 40'h8B_00000000);
        directed_cases[4]  = mk_case(0, 0, 0, 3, 7, 4'd1, 1, 40'h9F_00000000);
        directed_cases[5]  = mk_case(7, 1, 0, 0, 8, 4'd1, 0, 40'h37_00000000);
        directed_cases[6]  = mk_case(65535, 5, 0, 255, 255, 4'd5, 0, 40'h36_35_35_33_35);
        directed_cases[7]  = mk_case(65535, 127, 0, 4, 0, 4'd5, 0, 40'h36_35_35_33_35);
        directed_cases[8]  = mk_case(12345, 6, 0, 0, 0, UNTYPED, 0, 40'h0);
        directed_cases[9]  = mk_case(12345, 3, 0, 1, 2, UNTYPED, 0, 40'h0);
        directed_cases[10] = mk_case(9, 1, 1, 8, 0, 4'd2, 0, 40'hA3_B9_000000);
        directed_cases[11] = mk_case(0, 5, 1, 3, 0, UNTYPED, 0, 40'h0);
        directed_cases[12] = mk_case(65535, 5, 1, 0, 7, UNTYPED, 0, 40'h0);
        directed_cases[13] = mk_case(0, 2, 0, 0, 255, 4'd2, 0, 40'h30_30_000000);
        directed_cases[14] = mk_case(65535, 0, 1, 128, 128, 4'd0, 0, 40'h0);
        directed_cases[15] = mk_case(9876, 4, 0, 2, 0, UNTYPED, 0, 40'h0);
        directed_cases[16] = mk_case(10000, 5, 0, 3, 5, UNTYPED, 0, 40'h0);
        directed_cases[17] = mk_case(40960, 5, 1, 1, 1, UNTYPED, 0, 40'h0);
        directed_cases[18] = mk_case(1, 1, 0, 3, 8, 4'd1, 0, 40'h31_00000000);
        directed_cases[19] = mk_case(100, 3, 1, 4, 8, UNTYPED, 0, 40'h0);
        directed_cases[20] = mk_case(32768, 64, 0, 0, 0, UNTYPED, 0, 40'h0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cases[i]) begin
            send_word(directed_cases[i].w, pick_gap());
            if (directed_cases[i].n_typed == UNTYPED)
                predict_frames(directed_cases[i].w);
            else
                push_typed(directed_cases[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: begin
                    write_reg(CFG_WIDE_LEAD, 8'h00);
                    write_reg(CFG_WIDE_BASE, 8'h00);
                end
                1: begin
                    write_reg(CFG_WIDE_BASE, 8'hFF);
                    write_reg(CFG_WIDE_LEAD, 8'hFF);
                end
                2: begin
                    write_reg(CFG_WIDE_LEAD, BYTE_W'($urandom_range(0, 255)));
                    write_reg(CFG_WIDE_BASE, BYTE_W'($urandom_range(0, 255)));
                end
                default: begin
                    write_reg(CFG_WIDE_LEAD, 8'h5A);
                    write_reg(CFG_SPARE, 8'hC3);
                    write_reg(CFG_WIDE_BASE, 8'hF7);
                end
            endcase
            cfg_if.valid <= 1'b0;

            for (int k = 0; k < PHASE_WORDS; k++) begin
                w = random_word();
                // long result stall with the input kept busy
                if (phase == 0 && k == 10)
                    holds_asked++;
                if (phase == 1 && k == PHASE_WORDS / 2)
                    settle();
                send_word(w, (phase == 0 && k >= 10 && k < 40) ? 0 : pick_gap());
                predict_frames(w);
            end
        end

        settle();
        if (mismatches == 0 && frames_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
